// ===== rtl/core/ler_pkg.sv =====
// Shared constants, types and helpers for the line echo ring buffer.
`timescale 1ns / 1ps

package ler_pkg;

  localparam int unsigned LER_BUF_DEPTH = 32;
  localparam int unsigned LER_PTR_W     = $clog2(LER_BUF_DEPTH);

  localparam logic [7:0] CHAR_CR     = 8'd13;
  localparam logic [7:0] CHAR_LF     = 8'd10;
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;

  // One classified command handed from the front to the back.
  typedef struct packed {
    logic       is_cr;
    logic [7:0] data;
  } ler_cmd_t;

  function automatic logic [LER_PTR_W-1:0] ler_next_ptr(input logic [LER_PTR_W-1:0] ptr);
    logic [LER_PTR_W-1:0] nxt;
    if (ptr == LER_PTR_W'(LER_BUF_DEPTH - 1)) begin
      nxt = '0;
    end else begin
      nxt = ptr + 1'b1;
    end
    return nxt;
  endfunction

endpackage

// ===== rtl/core/ler_front.sv =====
// Front end: accepts received bytes, classifies them and queues the commands.
`timescale 1ns / 1ps

module ler_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  logic [7:0]        rx_byte_i,
  output logic              cmd_valid_o,
  output ler_pkg::ler_cmd_t cmd_o,
  input  logic              cmd_pop_i
);

  ler_pkg::ler_cmd_t slot_q [2];
  logic [1:0]        count_q, count_d;
  logic              wr_q, wr_d;
  logic              rd_q, rd_d;
  logic              do_push;
  logic              do_pop;
  ler_pkg::ler_cmd_t new_cmd;

  assign full_o      = (count_q == 2'd2);
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = slot_q[rd_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = cmd_pop_i && cmd_valid_o;

  always_comb begin
    new_cmd.is_cr = (rx_byte_i == ler_pkg::CHAR_CR);
    new_cmd.data  = rx_byte_i;
  end

  always_comb begin
    wr_d    = do_push ? ~wr_q : wr_q;
    rd_d    = do_pop ? ~rd_q : rd_q;
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
    end else begin
      count_q <= count_d;
      wr_q    <= wr_d;
      rd_q    <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= new_cmd;
    end
  end

endmodule

// ===== rtl/core/ler_back.sv =====
// Back end: line store, pointers and the sequencer that produces the output bytes.
`timescale 1ns / 1ps

module ler_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  ler_pkg::ler_cmd_t cmd_i,
  output logic              cmd_pop_o,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [7:0]        tx_byte_o,
  output logic              last_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LF1    = 3'd1;
  localparam logic [2:0] ST_REPLAY = 3'd2;
  localparam logic [2:0] ST_CR2    = 3'd3;
  localparam logic [2:0] ST_LF2    = 3'd4;
  localparam logic [2:0] ST_DOLLAR = 3'd5;
  localparam logic [2:0] ST_SPACE  = 3'd6;

  logic [2:0]                   state_q, state_d;
  logic [ler_pkg::LER_PTR_W-1:0] wp_q, wp_d;
  logic [ler_pkg::LER_PTR_W-1:0] rp_q, rp_d;
  logic [ler_pkg::LER_PTR_W-1:0] rp_next;
  logic [7:0]                   mem_q [ler_pkg::LER_BUF_DEPTH];
  logic [7:0]                   rdata_q;
  logic                         mem_we;

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       out_last_q;
  logic       out_ready;
  logic       emit;
  logic [7:0] emit_byte;
  logic       emit_last;

  assign empty_o   = !out_valid_q;
  assign tx_byte_o = out_byte_q;
  assign last_o    = out_last_q;
  assign out_ready = !out_valid_q || pop_i;
  assign rp_next   = ler_pkg::ler_next_ptr(rp_q);

  always_comb begin
    state_d   = state_q;
    wp_d      = wp_q;
    rp_d      = rp_q;
    cmd_pop_o = 1'b0;
    mem_we    = 1'b0;
    emit      = 1'b0;
    emit_byte = ler_pkg::CHAR_CR;
    emit_last = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && out_ready) begin
          cmd_pop_o = 1'b1;
          emit      = 1'b1;
          if (cmd_i.is_cr) begin
            emit_byte = ler_pkg::CHAR_CR;
            state_d   = ST_LF1;
          end else begin
            emit_byte = cmd_i.data;
            emit_last = 1'b1;
            mem_we    = 1'b1;
            wp_d      = ler_pkg::ler_next_ptr(wp_q);
          end
        end
      end
      ST_LF1: begin
        if (out_ready) begin
          emit      = 1'b1;
          emit_byte = ler_pkg::CHAR_LF;
          state_d   = (rp_q == wp_q) ? ST_CR2 : ST_REPLAY;
        end
      end
      ST_REPLAY: begin
        if (out_ready) begin
          emit      = 1'b1;
          emit_byte = rdata_q;
          rp_d      = rp_next;
          if (rp_next == wp_q) begin
            state_d = ST_CR2;
          end
        end
      end
      ST_CR2: begin
        if (out_ready) begin
          emit      = 1'b1;
          emit_byte = ler_pkg::CHAR_CR;
          state_d   = ST_LF2;
        end
      end
      ST_LF2: begin
        if (out_ready) begin
          emit      = 1'b1;
          emit_byte = ler_pkg::CHAR_LF;
          state_d   = ST_DOLLAR;
        end
      end
      ST_DOLLAR: begin
        if (out_ready) begin
          emit      = 1'b1;
          emit_byte = ler_pkg::CHAR_DOLLAR;
          state_d   = ST_SPACE;
        end
      end
      ST_SPACE: begin
        if (out_ready) begin
          emit      = 1'b1;
          emit_byte = ler_pkg::CHAR_SPACE;
          emit_last = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= '0;
      rp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= emit_byte;
      out_last_q <= emit_last;
    end
  end

  // The read address follows the next read pointer, so rdata_q always holds the
  // entry at rp_q. A replay is entered only from ST_LF1, after the carriage return is
  // taken in ST_IDLE, which keeps a same-cycle store write from being missed.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wp_q] <= cmd_i.data;
    end
    rdata_q <= mem_q[rp_d];
  end

endmodule

// ===== rtl/core/line_echo_ring_buffer.sv =====
// An accepted byte passes through the front-end command queue and then the output register.
// A plain byte is handled in ST_IDLE alone; a carriage return runs the sequencer through CR,
// LF, the N stored bytes replayed (at most 31), CR, LF, dollar and space.
// The sequencer delivers one output byte per cycle while the consumer keeps popping.
// Reset clears both pointers, the command queue and the output valid flag; the line
// store keeps its contents and needs no clearing pass.
`timescale 1ns / 1ps

module line_echo_ring_buffer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] tx_byte_o,
  output logic       last_o
);

  logic              cmd_valid;
  logic              cmd_pop;
  ler_pkg::ler_cmd_t cmd;

  ler_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .rx_byte_i   (rx_byte_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  ler_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .tx_byte_o   (tx_byte_o),
    .last_o      (last_o)
  );

endmodule

// ===== rtl/core/ler_checker.sv =====
// Port-level checks for the line echo ring buffer, bound to the top level.
`timescale 1ns / 1ps

module ler_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [7:0] tx_byte_o,
  input logic       last_o
);

  // Within one run, the next byte follows immediately after a transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !empty && !last_o |=> !empty)
    else $error("output run broke off before its last byte");

  // A carriage return never ends a run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && last_o |-> tx_byte_o != 8'd13)
    else $error("run ended on a carriage return");

  // A waiting result holds until its transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(tx_byte_o) && $stable(last_o))
    else $error("waiting result changed before transfer");

endmodule

bind line_echo_ring_buffer ler_checker u_ler_checker (.*);

// ===== dv/tb_line_echo_ring_buffer.sv =====
// Self-checking testbench for the line echo ring buffer, with random stimulus and a predictor.
`timescale 1ns / 1ps

module tb_line_echo_ring_buffer;

  localparam int unsigned NUM_PHASES  = 3;
  localparam int unsigned STALL_LEN   = 400;
  localparam int unsigned WDOG_LIMIT  = 3000;
  localparam int unsigned TAIL_CYCLES = 20;
  localparam int unsigned MAX_REPORTS = 10;

  typedef logic [ler_pkg::LER_PTR_W-1:0] line_ptr_t;

  typedef struct {
    logic [7:0]  ch;
    int unsigned phase;
    bit          drain;
  } rx_item_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } tx_char_t;

  logic       clk_i     = 1'b0;
  logic       rst_ni    = 1'b0;
  logic       push      = 1'b0;
  logic       full;
  logic [7:0] rx_byte_i = 8'h00;
  logic       empty;
  logic       pop       = 1'b0;
  logic [7:0] tx_byte_o;
  logic       last_o;

  // Sender and receiver idle percentages per phase.
  int unsigned tx_idle_pct [NUM_PHASES] = '{16, 85, 0};
  int unsigned rx_idle_pct [NUM_PHASES] = '{85, 16, 0};

  rx_item_t    rx_items[$];
  tx_char_t    echo_expect[$];

  logic [7:0]  line_mem [ler_pkg::LER_BUF_DEPTH];
  line_ptr_t   wr_ptr = '0;
  line_ptr_t   rd_ptr = '0;

  int unsigned phase_now     = 0;
  int unsigned bytes_sent    = 0;
  int unsigned chars_checked = 0;
  int unsigned err_count     = 0;
  int unsigned full_cycles   = 0;
  int unsigned longest_line  = 0;
  int unsigned stall_left    = 0;
  bit          rx_stall_done = 1'b0;
  int unsigned idle_cycles   = 0;
  logic        drv_push_nxt;
  logic        mon_pop_nxt;
  tx_char_t    got_char;
  tx_char_t    exp_char;

  line_echo_ring_buffer i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .rx_byte_i (rx_byte_i),
    .empty     (empty),
    .pop       (pop),
    .tx_byte_o (tx_byte_o),
    .last_o    (last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic line_ptr_t bump_ptr(line_ptr_t p);
    return (p == line_ptr_t'(ler_pkg::LER_BUF_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Works out every character the block sends back for one received byte.
  task automatic predict_echo(input logic [7:0] ch);
    if (ch != ler_pkg::CHAR_CR) begin
      echo_expect.push_back('{ch, 1'b1});
      line_mem[wr_ptr] = ch;
      wr_ptr = bump_ptr(wr_ptr);
    end else begin
      echo_expect.push_back('{ler_pkg::CHAR_CR, 1'b0});
      echo_expect.push_back('{ler_pkg::CHAR_LF, 1'b0});
      while (rd_ptr != wr_ptr) begin
        echo_expect.push_back('{line_mem[rd_ptr], 1'b0});
        rd_ptr = bump_ptr(rd_ptr);
      end
      echo_expect.push_back('{ler_pkg::CHAR_CR, 1'b0});
      echo_expect.push_back('{ler_pkg::CHAR_LF, 1'b0});
      echo_expect.push_back('{ler_pkg::CHAR_DOLLAR, 1'b0});
      echo_expect.push_back('{ler_pkg::CHAR_SPACE, 1'b1});
    end
  endtask

  task automatic add_byte(input logic [7:0] ch, input int unsigned ph, input bit drain);
    rx_items.push_back('{ch, ph, drain});
  endtask

  // Queues n printable-or-not characters, never a carriage return, then the carriage return.
  task automatic add_line(input int unsigned n, input int unsigned ph, input bit drain);
    logic [7:0] ch;
    for (int unsigned k = 0; k < n; k++) begin
      do ch = 8'($urandom_range(255)); while (ch == ler_pkg::CHAR_CR);
      add_byte(ch, ph, drain && (k == 0));
    end
    add_byte(ler_pkg::CHAR_CR, ph, drain && (n == 0));
    if (n > longest_line) longest_line = n;
  endtask

  task automatic add_random_mix(input int unsigned ph, input int unsigned upto);
    int unsigned pick;
    logic [7:0]  ch;
    while (rx_items.size() < upto) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        if ($urandom_range(9) == 0) begin
          add_line($urandom_range(31, 20), ph, $urandom_range(9) == 0);
        end else begin
          add_line($urandom_range(10), ph, $urandom_range(24) == 0);
        end
      end else if (pick < 88) begin
        add_byte(ler_pkg::CHAR_CR, ph, 1'b0);
      end else begin
        // A broken line: characters that are never followed by a carriage return here.
        for (int unsigned k = $urandom_range(6, 1); k > 0; k--) begin
          do ch = 8'($urandom_range(255)); while (ch == ler_pkg::CHAR_CR);
          add_byte(ch, ph, 1'b0);
        end
      end
    end
  endtask

  // Sender: offers the front of the item queue, holding it steady while the block is full.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push      <= 1'b0;
      rx_byte_i <= 8'h00;
    end else begin
      if (push && !full) begin
        predict_echo(rx_byte_i);
        void'(rx_items.pop_front());
        bytes_sent++;
      end
      drv_push_nxt = 1'b0;
      if (push && full) begin
        drv_push_nxt = 1'b1;
      end else if (rx_items.size() != 0) begin
        if (!(rx_items[0].drain && echo_expect.size() != 0)) begin
          rx_items[0].drain = 1'b0;
          phase_now    = rx_items[0].phase;
          drv_push_nxt = ($urandom_range(99) >= tx_idle_pct[phase_now]);
        end
      end
      if (drv_push_nxt && !(push && full)) begin
        rx_byte_i <= rx_items[0].ch;
      end
      push <= drv_push_nxt;
    end
  end

  // Receiver: checks every transfer against the oldest expected character.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (full) full_cycles++;
      if (pop && !empty) begin
        chars_checked++;
        got_char = '{tx_byte_o, last_o};
        if (echo_expect.size() == 0) begin
          err_count++;
          if (err_count <= MAX_REPORTS) begin
            $display("%0t: unexpected character %02h last %b", $realtime, tx_byte_o, last_o);
          end
        end else begin
          exp_char = echo_expect.pop_front();
          if (got_char !== exp_char) begin
            err_count++;
            if (err_count <= MAX_REPORTS) begin
              $display("%0t: expected %02h last %b, got %02h last %b", $realtime,
                       exp_char.ch, exp_char.last, tx_byte_o, last_o);
            end
          end
        end
      end
      // One long hold-off once the sender runs without gaps, so the block backs up.
      if (phase_now == 2 && !rx_stall_done) begin
        stall_left    = STALL_LEN;
        rx_stall_done = 1'b1;
      end
      if (stall_left != 0) begin
        stall_left--;
        mon_pop_nxt = 1'b0;
      end else begin
        mon_pop_nxt = ($urandom_range(99) >= rx_idle_pct[phase_now]);
      end
      pop <= mon_pop_nxt;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WDOG_LIMIT) begin
          $display("Watchdog: no transfer for %0d cycles, %0d bytes and %0d characters left",
                   idle_cycles, rx_items.size(), echo_expect.size());
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

  initial begin
    // Carriage return on an empty store gives only the two line breaks and the prompt.
    add_byte(ler_pkg::CHAR_CR, 0, 1'b1);
    add_byte(8'h00, 0, 1'b0);
    add_byte(8'hFF, 0, 1'b0);
    add_byte(8'h7F, 0, 1'b0);
    add_byte(8'h80, 0, 1'b0);
    add_byte(ler_pkg::CHAR_LF, 0, 1'b0);
    add_byte(ler_pkg::CHAR_DOLLAR, 0, 1'b0);
    add_byte(ler_pkg::CHAR_SPACE, 0, 1'b0);
    add_byte(8'h0C, 0, 1'b0);
    add_byte(8'h0E, 0, 1'b0);
    add_byte(ler_pkg::CHAR_CR, 0, 1'b0);
    add_byte(ler_pkg::CHAR_CR, 0, 1'b0);
    // Longest replay, then a full store whose contents are lost, then a wrap past it.
    add_line(ler_pkg::LER_BUF_DEPTH - 1, 0, 1'b1);
    add_line(ler_pkg::LER_BUF_DEPTH, 0, 1'b0);
    add_line(ler_pkg::LER_BUF_DEPTH + 8, 0, 1'b0);
    add_random_mix(0, 160);
    add_line($urandom_range(6), 1, 1'b1);
    add_random_mix(1, 260);
    add_line($urandom_range(6), 2, 1'b1);
    add_line(ler_pkg::LER_BUF_DEPTH + 13, 2, 1'b0);
    add_random_mix(2, 370);

    wait (rst_ni);
    while (rx_items.size() != 0 || echo_expect.size() != 0 || push) begin
      @(posedge clk_i);
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d bytes and checked %0d echoed characters under three idle profiles.",
             bytes_sent, chars_checked);
    $display("Input held off by full for %0d cycles; longest line %0d bytes; %0d mismatches.",
             full_cycles, longest_line, err_count);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/ler_pkg.sv
rtl/core/ler_front.sv
rtl/core/ler_back.sv
rtl/core/line_echo_ring_buffer.sv
rtl/core/ler_checker.sv
dv/tb_line_echo_ring_buffer.sv
